// ===== rtl/core/bpri_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpri_pkg
// Constants and the command format shared by the front end, the command
// queue and the back end of the bad pixel row interpolator.
// ----------------------------------------------------------------------------
package bpri_pkg;

  localparam int MAX_RUN     = 63;
  localparam int PIXEL_BITS  = 16;
  localparam int PIX_W       = 16;
  localparam int RUN_W       = $clog2(MAX_RUN + 1);
  localparam int IDX_W       = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [PIX_W-1:0] PIX_MASK = PIX_W'((33'd1 << PIXEL_BITS) - 33'd1);
  localparam logic [RUN_W-1:0] RUN_FULL = RUN_W'(MAX_RUN);

  // One classified pixel. For a bad pixel run_len is the run store slot it
  // goes to; for a good pixel it is the number of held pixels it closes.
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             bad;
    logic             le;
    logic             ovf;
    logic [RUN_W-1:0] run_len;
    logic             left_valid;
    logic [PIX_W-1:0] left_value;
    logic [PIX_W-1:0] close_value;
  } cmd_t;

endpackage

// ===== rtl/core/bpri_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpri_if
// Valid/ready channels of the bad pixel row interpolator: pixel input,
// result output and the configuration write channel.
// ----------------------------------------------------------------------------
interface bpri_pix_if;
  logic                      valid;
  logic                      ready;
  logic [bpri_pkg::PIX_W-1:0] pixel_value;
  logic                      pixel_bad;
  logic                      line_end;

  modport source (output valid, pixel_value, pixel_bad, line_end, input ready);
  modport sink   (input valid, pixel_value, pixel_bad, line_end, output ready);
endinterface

interface bpri_res_if;
  logic                      valid;
  logic                      ready;
  logic [bpri_pkg::PIX_W-1:0] out_value;
  logic                      was_replaced;
  logic                      out_line_end;
  logic                      run_overflow;

  modport source (output valid, out_value, was_replaced, out_line_end, run_overflow,
                  input ready);
  modport sink   (input valid, out_value, was_replaced, out_line_end, run_overflow,
                  output ready);
endinterface

interface bpri_cfg_if;
  logic valid;
  logic ready;
  logic correction_enable;

  modport source (output valid, correction_enable, input ready);
  modport sink   (input valid, correction_enable, output ready);
endinterface

// ===== rtl/core/bpri_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpri_front
// Accepts pixels, tracks the left neighbour and the run length, and turns
// each pixel into one command for the back end.
// ----------------------------------------------------------------------------
module bpri_front (
  input  logic                 clk,
  input  logic                 rst,
  bpri_pix_if.sink             pix_in,
  bpri_cfg_if.sink             cfg,
  input  logic                 q_ready,
  output logic                 push,
  output bpri_pkg::cmd_t       push_cmd
);

  logic                          enable;
  logic [bpri_pkg::PIX_W-1:0]    left_value;
  logic                          left_valid;
  logic [bpri_pkg::RUN_W-1:0]    run_length;

  logic [bpri_pkg::PIX_W-1:0]    pix;
  logic                          bad;
  logic                          ovf;
  logic [bpri_pkg::RUN_W-1:0]    slot;
  logic [bpri_pkg::PIX_W:0]      sum;

  assign cfg.ready    = 1'b1;
  assign pix_in.ready = q_ready;
  assign push         = pix_in.valid & q_ready;

  assign pix  = pix_in.pixel_value & bpri_pkg::PIX_MASK;
  assign bad  = pix_in.pixel_bad & enable;
  assign ovf  = bad && (run_length == bpri_pkg::RUN_FULL);
  assign slot = ovf ? '0 : run_length;
  assign sum  = {1'b0, left_value} + {1'b0, pix};

  always_comb begin
    push_cmd.pix         = pix;
    push_cmd.bad         = bad;
    push_cmd.le          = pix_in.line_end;
    push_cmd.ovf         = ovf;
    push_cmd.run_len     = bad ? slot : run_length;
    push_cmd.left_valid  = left_valid;
    push_cmd.left_value  = left_value;
    push_cmd.close_value = left_valid ? sum[bpri_pkg::PIX_W:1] : pix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b0;
      left_value <= '0;
      left_valid <= 1'b0;
      run_length <= '0;
    end else begin
      if (cfg.valid) begin
        enable <= cfg.correction_enable;
      end
      if (push) begin
        if (!bad) begin
          run_length <= '0;
          left_value <= pix;
          left_valid <= !pix_in.line_end;
        end else if (pix_in.line_end) begin
          // The whole run leaves with this pixel and the row is over.
          run_length <= '0;
          left_value <= '0;
          left_valid <= 1'b0;
        end else begin
          run_length <= slot + bpri_pkg::RUN_W'(1);
        end
      end
    end
  end

endmodule

// ===== rtl/core/bpri_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpri_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module bpri_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bpri_pkg::cmd_t push_cmd,
  output logic           q_ready,
  input  logic           pop,
  output logic           q_nonempty,
  output bpri_pkg::cmd_t head
);

  bpri_pkg::cmd_t                 entries [bpri_pkg::QUEUE_DEPTH];
  logic [bpri_pkg::QPTR_W-1:0]    wr_ptr;
  logic [bpri_pkg::QPTR_W-1:0]    rd_ptr;
  logic [bpri_pkg::QCNT_W-1:0]    count;
  logic                           do_push;
  logic                           do_pop;

  assign q_ready    = (count != bpri_pkg::QCNT_W'(bpri_pkg::QUEUE_DEPTH));
  assign q_nonempty = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push & q_ready;
  assign do_pop     = pop & q_nonempty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + bpri_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + bpri_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + bpri_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - bpri_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/core/bpri_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpri_back
// Executes commands: holds bad pixels in the run store, closes runs with
// the neighbour mean, flushes runs at row end or on overflow, and drives
// the registered result channel.
// ----------------------------------------------------------------------------
module bpri_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_nonempty,
  input  bpri_pkg::cmd_t head,
  output logic           pop,
  bpri_res_if.source     res_out
);

  typedef enum logic [4:0] {
    S_IDLE       = 5'b00001,
    S_BODY       = 5'b00010,
    S_CLOSE      = 5'b00100,
    S_FINAL      = 5'b01000,
    S_FLUSH_ADDR = 5'b10000
  } state_t;

  // The memory read cycle of a flush without a left neighbour is tracked
  // by a separate flag rather than its own state.
  state_t                         state, state_next;
  logic                           fetched, fetched_next;
  bpri_pkg::cmd_t                 cmd, cmd_next;
  logic [bpri_pkg::IDX_W-1:0]     idx, idx_next;
  logic [bpri_pkg::RUN_W-1:0]     flush_len, flush_len_next;
  logic                           flush_ovf, flush_ovf_next;
  logic                           flush_le, flush_le_next;

  logic [bpri_pkg::PIX_W-1:0]     run_store [bpri_pkg::MAX_RUN];
  logic [bpri_pkg::PIX_W-1:0]     rdata;
  logic                           wr_en;
  logic [bpri_pkg::IDX_W-1:0]     wr_addr;
  logic [bpri_pkg::PIX_W-1:0]     wr_data;

  logic                           o_valid;
  logic [bpri_pkg::PIX_W-1:0]     o_value;
  logic                           o_rep;
  logic                           o_le;
  logic                           o_ovf;

  logic                           can_put;
  logic                           emit;
  logic [bpri_pkg::PIX_W-1:0]     e_value;
  logic                           e_rep;
  logic                           e_le;
  logic                           e_ovf;
  logic                           flush_last;
  logic                           close_last;
  logic                           simple_good;
  logic                           simple_bad;

  assign can_put     = !o_valid || res_out.ready;
  assign flush_last  = (bpri_pkg::RUN_W'(idx) == flush_len - bpri_pkg::RUN_W'(1));
  assign close_last  = (bpri_pkg::RUN_W'(idx) == cmd.run_len - bpri_pkg::RUN_W'(1));
  assign simple_good = !head.bad && (head.run_len == '0);
  assign simple_bad  = head.bad && !head.ovf && !head.le;

  always_comb begin
    state_next     = state;
    fetched_next   = fetched;
    cmd_next       = cmd;
    idx_next       = idx;
    flush_len_next = flush_len;
    flush_ovf_next = flush_ovf;
    flush_le_next  = flush_le;
    pop            = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = head.run_len[bpri_pkg::IDX_W-1:0];
    wr_data        = head.pix;
    emit           = 1'b0;
    e_value        = cmd.pix;
    e_rep          = 1'b0;
    e_le           = 1'b0;
    e_ovf          = 1'b0;

    case (state)
      S_IDLE: begin
        if (q_nonempty) begin
          if (simple_good) begin
            if (can_put) begin
              pop     = 1'b1;
              emit    = 1'b1;
              e_value = head.pix;
              e_le    = head.le;
            end
          end else if (simple_bad) begin
            pop   = 1'b1;
            wr_en = 1'b1;
          end else begin
            pop      = 1'b1;
            cmd_next = head;
            idx_next = '0;
            if (!head.bad) begin
              state_next = S_CLOSE;
            end else if (head.ovf) begin
              flush_len_next = bpri_pkg::RUN_FULL;
              flush_ovf_next = 1'b1;
              flush_le_next  = 1'b0;
              fetched_next   = 1'b0;
              state_next     = S_FLUSH_ADDR;
            end else begin
              state_next = S_BODY;
            end
          end
        end
      end
      S_BODY: begin
        // Store the bad pixel; at row end the run, this pixel included,
        // leaves with the left neighbour only, or unchanged without one.
        wr_en   = 1'b1;
        wr_addr = cmd.run_len[bpri_pkg::IDX_W-1:0];
        wr_data = cmd.pix;
        if (cmd.le) begin
          flush_len_next = cmd.run_len + bpri_pkg::RUN_W'(1);
          flush_ovf_next = 1'b0;
          flush_le_next  = 1'b1;
          fetched_next   = 1'b0;
          idx_next       = '0;
          state_next     = S_FLUSH_ADDR;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_CLOSE: begin
        if (can_put) begin
          emit    = 1'b1;
          e_value = cmd.close_value;
          e_rep   = 1'b1;
          if (close_last) begin
            idx_next   = '0;
            state_next = S_FINAL;
          end else begin
            idx_next = idx + bpri_pkg::IDX_W'(1);
          end
        end
      end
      S_FINAL: begin
        if (can_put) begin
          emit       = 1'b1;
          e_value    = cmd.pix;
          e_le       = cmd.le;
          state_next = S_IDLE;
        end
      end
      S_FLUSH_ADDR: begin
        if (cmd.left_valid || fetched) begin
          if (can_put) begin
            emit         = 1'b1;
            e_value      = cmd.left_valid ? cmd.left_value : rdata;
            e_rep        = cmd.left_valid;
            e_le         = flush_le && flush_last;
            e_ovf        = flush_ovf;
            fetched_next = 1'b0;
            if (flush_last) begin
              idx_next   = '0;
              state_next = flush_ovf ? S_BODY : S_IDLE;
            end else begin
              idx_next = idx + bpri_pkg::IDX_W'(1);
            end
          end
        end else begin
          fetched_next = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      run_store[wr_addr] <= wr_data;
    end
    rdata <= run_store[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      fetched <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      state   <= state_next;
      fetched <= fetched_next;
      if (emit) begin
        o_valid <= 1'b1;
      end else if (res_out.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd       <= cmd_next;
    idx       <= idx_next;
    flush_len <= flush_len_next;
    flush_ovf <= flush_ovf_next;
    flush_le  <= flush_le_next;
    if (emit) begin
      o_value <= e_value;
      o_rep   <= e_rep;
      o_le    <= e_le;
      o_ovf   <= e_ovf;
    end
  end

  assign res_out.valid        = o_valid;
  assign res_out.out_value    = o_value;
  assign res_out.was_replaced = o_rep;
  assign res_out.out_line_end = o_le;
  assign res_out.run_overflow = o_ovf;

  a_flush_idx_in_run: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH_ADDR) |-> (bpri_pkg::RUN_W'(idx) < flush_len))
    else $error("flush index beyond run length");

  a_no_write_in_flush: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH_ADDR) |-> !wr_en)
    else $error("run store written during a flush");

  a_raw_needs_fetch: assert property (@(posedge clk) disable iff (rst)
    (emit && state == S_FLUSH_ADDR && !cmd.left_valid) |-> $past(fetched_next))
    else $error("raw run pixel emitted without a store read");

  a_ovf_then_store: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH_ADDR && emit && flush_last && flush_ovf) |=> (state == S_BODY))
    else $error("overflow flush not followed by storing the new pixel");

  a_close_is_good: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLOSE) |-> (!cmd.bad && cmd.run_len != '0))
    else $error("run closed by a bad pixel or an empty run");

endmodule

// ===== rtl/core/bad_pixel_row_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bad_pixel_row_interpolator
// Replaces bad pixels of a row by the mean of their good neighbours.
// ----------------------------------------------------------------------------
// Channels: pix_in takes pixels in row order with a bad flag and a line end
// mark; res_out gives one result per pixel, in input order; cfg writes the
// correction enable bit, which the user must write only while the block is
// idle; the block itself does not enforce this. A request on pix_in is
// classified by the front end in its cycle of acceptance and queued (four
// entries); the back end turns commands into results through a one-entry
// output register. A good pixel with no held run passes from the queue
// through the output register to res_out. Bad pixels produce nothing until
// a good pixel, a row end or a full run store (63 pixels) releases them.
// Pass-through pixels and bad pixels that start or extend a run, with no
// overflow and no row end, are handled straight from the queue head. A good
// pixel closing a run of N gives N replaced results and then its own. A run
// flushed with a left neighbour gives one result a cycle while res_out is
// ready; without one each result waits for the registered run store read.
// Reset clears the queue, the output register, the run and the left
// neighbour, and disables correction; the run store is not cleared.
// When res_out stalls, the queue fills and pix_in.ready drops.
// ----------------------------------------------------------------------------
module bad_pixel_row_interpolator (
  input  logic       clk,
  input  logic       rst,
  bpri_pix_if.sink   pix_in,
  bpri_cfg_if.sink   cfg,
  bpri_res_if.source res_out
);

  logic           q_ready;
  logic           push;
  bpri_pkg::cmd_t push_cmd;
  logic           pop;
  logic           q_nonempty;
  bpri_pkg::cmd_t head;

  bpri_front u_front (
    .clk      (clk),
    .rst      (rst),
    .pix_in   (pix_in),
    .cfg      (cfg),
    .q_ready  (q_ready),
    .push     (push),
    .push_cmd (push_cmd)
  );

  bpri_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .q_ready    (q_ready),
    .pop        (pop),
    .q_nonempty (q_nonempty),
    .head       (head)
  );

  bpri_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .head       (head),
    .pop        (pop),
    .res_out    (res_out)
  );

endmodule

// ===== tb/bad_pixel_row_interpolator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bad_pixel_row_interpolator_tb
// Drives pixel rows with bad flags and row ends into the interpolator and
// checks every result against a scoreboard that predicts the corrected row,
// under random gaps and backpressure, long output stalls and enable changes.
// ----------------------------------------------------------------------------
module bad_pixel_row_interpolator_tb;

  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int IDLE_PCT = 38;
  localparam logic [bpri_pkg::PIX_W-1:0] PIX_MAX = '1;

  typedef struct packed {
    logic [bpri_pkg::PIX_W-1:0] value;
    logic                       replaced;
    logic                       line_end;
    logic                       overflow;
  } result_t;

  class row_correction_scoreboard;
    logic                       enable;
    logic [bpri_pkg::PIX_W-1:0] left_value;
    logic                       left_valid;
    int                         run_len;
    logic [bpri_pkg::PIX_W-1:0] run_store [bpri_pkg::MAX_RUN];
    result_t                    expected_pixels [$];
    int                         errors;

    function new();
      enable = 1'b0;
      left_value = '0;
      left_valid = 1'b0;
      run_len = 0;
      errors = 0;
    endfunction

    function void push(logic [bpri_pkg::PIX_W-1:0] v, logic rep, logic le, logic ovf);
      result_t r;
      r.value = v;
      r.replaced = rep;
      r.line_end = le;
      r.overflow = ovf;
      expected_pixels.push_back(r);
    endfunction

    // Held pixels released with only the left neighbour known.
    function void flush_left(logic last_le, logic ovf);
      logic le;
      for (int i = 0; i < run_len; i++) begin
        le = (i + 1 == run_len) ? last_le : 1'b0;
        if (left_valid) push(left_value, 1'b1, le, ovf);
        else push(run_store[i], 1'b0, le, ovf);
      end
      run_len = 0;
    endfunction

    function void note_pixel(logic [bpri_pkg::PIX_W-1:0] raw, logic bad_in, logic le);
      logic [bpri_pkg::PIX_W-1:0] pix;
      logic [bpri_pkg::PIX_W:0]   sum;
      pix = raw & bpri_pkg::PIX_MASK;
      if (!(bad_in && enable)) begin
        sum = {1'b0, left_value} + {1'b0, pix};
        for (int i = 0; i < run_len; i++) begin
          push(left_valid ? sum[bpri_pkg::PIX_W:1] : pix, 1'b1, 1'b0, 1'b0);
        end
        run_len = 0;
        push(pix, 1'b0, le, 1'b0);
        left_value = pix;
        left_valid = !le;
        return;
      end
      if (run_len >= bpri_pkg::MAX_RUN) flush_left(1'b0, 1'b1);
      run_store[run_len] = pix;
      run_len++;
      if (le) begin
        flush_left(1'b1, 1'b0);
        left_valid = 1'b0;
        left_value = '0;
      end
    endfunction

    function void check_result(result_t act);
      result_t exp;
      if (expected_pixels.size() == 0) begin
        $display("%0t ERROR unexpected result: value %h rep %b le %b ovf %b",
                 $time, act.value, act.replaced, act.line_end, act.overflow);
        errors++;
        return;
      end
      exp = expected_pixels.pop_front();
      if (act !== exp) begin
        $display("%0t ERROR expected value %h rep %b le %b ovf %b,",
                 $time, exp.value, exp.replaced, exp.line_end, exp.overflow,
                 " actual value %h rep %b le %b ovf %b",
                 act.value, act.replaced, act.line_end, act.overflow);
        errors++;
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  bpri_pix_if pix_if ();
  bpri_res_if res_if ();
  bpri_cfg_if cfg_if ();

  row_correction_scoreboard sb = new();
  bit quiet;
  int stall_left;
  int sent;
  int cycles;

  bad_pixel_row_interpolator i_dut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_if),
    .cfg     (cfg_if),
    .res_out (res_if)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result side: random backpressure, or a counted hold-off when requested.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      res_if.ready = 1'b0;
      stall_left = stall_left - 1;
    end else begin
      res_if.ready = quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_if.valid && cfg_if.ready) sb.enable = cfg_if.correction_enable;
      if (pix_if.valid && pix_if.ready) begin
        sb.note_pixel(pix_if.pixel_value, pix_if.pixel_bad, pix_if.line_end);
      end
      if (res_if.valid && res_if.ready) begin
        sb.check_result(result_t'({res_if.out_value, res_if.was_replaced,
                                   res_if.out_line_end, res_if.run_overflow}));
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  function automatic logic [bpri_pkg::PIX_W-1:0] rand_pix();
    case ($urandom_range(7))
      0: return '0;
      1: return PIX_MAX;
      default: return bpri_pkg::PIX_W'($urandom);
    endcase
  endfunction

  task automatic send_pixel(input logic [bpri_pkg::PIX_W-1:0] v, input logic b,
                            input logic le);
    @(negedge clk);
    if (!quiet) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        pix_if.valid = 1'b0;
        @(negedge clk);
      end
    end
    pix_if.valid = 1'b1;
    pix_if.pixel_value = v;
    pix_if.pixel_bad = b;
    pix_if.line_end = le;
    do @(posedge clk); while (!pix_if.ready);
    sent++;
  endtask

  // Lets every expected result come out, then gives the back end time to
  // finish any held-pixel requests that produce no result.
  task automatic wait_drained();
    @(negedge clk);
    pix_if.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_enable(input logic en);
    wait_drained();
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.correction_enable = en;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic send_random_rows(input int count);
    int stop_at;
    int len;
    logic lead;
    logic end_on_bad;
    stop_at = sent + count;
    while (sent < stop_at) begin
      case ($urandom_range(11))
        0: begin
          // Long run that may overflow the run store.
          lead = 1'($urandom_range(1));
          end_on_bad = 1'($urandom_range(1));
          len = $urandom_range(60, 70);
          if (lead) send_pixel(rand_pix(), 1'b0, 1'b0);
          for (int i = 0; i < len; i++) begin
            send_pixel(rand_pix(), 1'b1, end_on_bad && (i == len - 1));
          end
          if (!end_on_bad) send_pixel(rand_pix(), 1'b0, 1'b1);
        end
        1: begin
          len = $urandom_range(1, 4);
          for (int i = 0; i < len; i++) begin
            send_pixel(rand_pix(), 1'($urandom_range(1)), 1'($urandom_range(1)));
          end
        end
        default: begin
          len = $urandom_range(1, 16);
          for (int i = 0; i < len; i++) begin
            send_pixel(rand_pix(), $urandom_range(99) < 35, i == len - 1);
          end
        end
      endcase
    end
  endtask

  initial begin
    rst = 1'b1;
    quiet = 1'b0;
    stall_left = 0;
    sent = 0;
    pix_if.valid = 1'b0;
    pix_if.pixel_value = '0;
    pix_if.pixel_bad = 1'b0;
    pix_if.line_end = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.correction_enable = 1'b0;
    res_if.ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Correction is off after reset, so bad flags are ignored.
    send_pixel(PIX_MAX, 1'b1, 1'b0);
    send_pixel(16'h0001, 1'b1, 1'b1);
    write_enable(1'b1);

    send_pixel(16'h0000, 1'b0, 1'b0);
    send_pixel(16'h1234, 1'b1, 1'b0);
    send_pixel(PIX_MAX, 1'b0, 1'b0);
    send_pixel(16'hABCD, 1'b1, 1'b0);
    send_pixel(16'h0002, 1'b1, 1'b0);
    send_pixel(PIX_MAX, 1'b0, 1'b1);
    // A run at the start of a row only has a right neighbour.
    send_pixel(16'h5555, 1'b1, 1'b0);
    send_pixel(16'hAAAA, 1'b0, 1'b0);
    send_pixel(16'h0F0F, 1'b1, 1'b1);
    // A row that ends in a run with no good pixel at all stays unchanged.
    send_pixel(16'h1111, 1'b1, 1'b0);
    send_pixel(16'h2222, 1'b1, 1'b1);
    // Disabling with a run held: the next pixel closes the run as good.
    send_pixel(16'h8000, 1'b0, 1'b0);
    send_pixel(16'h0001, 1'b1, 1'b0);
    write_enable(1'b0);
    send_pixel(16'h7FFF, 1'b1, 1'b0);
    send_pixel(16'h0003, 1'b0, 1'b1);
    write_enable(1'b1);
    // Full run store with a left neighbour.
    send_pixel(16'h4321, 1'b0, 1'b0);
    for (int i = 0; i <= bpri_pkg::MAX_RUN; i++) send_pixel(rand_pix(), 1'b1, 1'b0);
    send_pixel(16'h0000, 1'b0, 1'b1);

    // The receiver holds off while the sender keeps offering requests.
    stall_left = 300;
    send_random_rows(60);
    wait_drained();
    write_enable(1'b0);
    send_random_rows(30);
    write_enable(1'b1);
    quiet = 1'b1;
    send_random_rows(40);
    quiet = 1'b0;
    send_random_rows(60);

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
